/* sv/cfpi_pkg.sv */
// Shared widths, constants and stage payload types for the Catmull-Rom interpolator.
// No dependencies; every other file in the block uses it by scoped names.
package cfpi_pkg;

  localparam int SAMPLE_BITS   = 16;
  localparam int FRACTION_BITS = 16;

  // Doubled coefficient widths: |2a0| < 2^18, |2a1| < 2^19, |2a2| < 2^16.
  localparam int C0_W = SAMPLE_BITS + 3;
  localparam int C1_W = SAMPLE_BITS + 4;
  localparam int C2_W = SAMPLE_BITS + 1;
  localparam int M_W  = FRACTION_BITS + 1;

  // Horner partial sums.
  localparam int T1_W  = C1_W + FRACTION_BITS + 1;
  localparam int T2_W  = T1_W + M_W;
  localparam int LO_W  = T2_W / 2;
  localparam int HI_W  = T2_W - LO_W;
  localparam int X_W   = T2_W + M_W + 1;
  localparam int SHIFT = 3 * FRACTION_BITS + 1;
  localparam int Q_W   = X_W - SHIFT;

  localparam logic [M_W-1:0] UNIT = M_W'(1) << FRACTION_BITS;

  typedef struct packed {
    logic signed [C0_W-1:0]        c0;
    logic signed [C1_W-1:0]        c1;
    logic signed [C2_W-1:0]        c2;
    logic signed [SAMPLE_BITS-1:0] p1;
    logic        [M_W-1:0]         m;
  } coef_t;

  typedef logic signed [X_W-1:0] acc_t;

endpackage

/* sv/cfpi_coef.sv */
// First stage: doubled Catmull-Rom coefficients and the clamped fraction.
// Depends on cfpi_pkg.
module cfpi_coef (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    valid_i,
  input  logic signed [cfpi_pkg::SAMPLE_BITS-1:0] p0_i,
  input  logic signed [cfpi_pkg::SAMPLE_BITS-1:0] p1_i,
  input  logic signed [cfpi_pkg::SAMPLE_BITS-1:0] p2_i,
  input  logic signed [cfpi_pkg::SAMPLE_BITS-1:0] p3_i,
  input  logic        [cfpi_pkg::M_W-1:0]         fraction_i,
  output logic                                    valid_o,
  output cfpi_pkg::coef_t                         coef_o
);

  localparam int EXT = cfpi_pkg::C1_W - cfpi_pkg::SAMPLE_BITS;
  localparam int SB  = cfpi_pkg::SAMPLE_BITS;

  logic signed [cfpi_pkg::C1_W-1:0] e0, e1, e2, e3;
  logic signed [cfpi_pkg::C1_W-1:0] c0_full, c1_full, c2_full;
  cfpi_pkg::coef_t coef_d, coef_q;
  logic valid_q;

  assign e0 = {{EXT{p0_i[SB-1]}}, p0_i};
  assign e1 = {{EXT{p1_i[SB-1]}}, p1_i};
  assign e2 = {{EXT{p2_i[SB-1]}}, p2_i};
  assign e3 = {{EXT{p3_i[SB-1]}}, p3_i};

  // 2a0 = -p0 + 3p1 - 3p2 + p3, 2a1 = 2p0 - 5p1 + 4p2 - p3, 2a2 = p2 - p0
  assign c0_full = e3 - e0 + (e1 <<< 1) + e1 - (e2 <<< 1) - e2;
  assign c1_full = (e0 <<< 1) - (e1 <<< 2) - e1 + (e2 <<< 2) - e3;
  assign c2_full = e2 - e0;

  always_comb begin
    coef_d.c0 = c0_full[cfpi_pkg::C0_W-1:0];
    coef_d.c1 = c1_full;
    coef_d.c2 = c2_full[cfpi_pkg::C2_W-1:0];
    coef_d.p1 = p1_i;
    // Hold the fraction at one: no extrapolation past the interval end.
    coef_d.m  = (fraction_i > cfpi_pkg::UNIT) ? cfpi_pkg::UNIT : fraction_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    coef_q <= coef_d;
  end

  assign valid_o = valid_q;
  assign coef_o  = coef_q;

endmodule

/* sv/cfpi_horner.sv */
// Stages two to five: exact Horner evaluation of the doubled, scaled estimate.
// Depends on cfpi_pkg; the last multiply is split into two partial products.
module cfpi_horner (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  cfpi_pkg::coef_t coef_i,
  output logic            valid_o,
  output cfpi_pkg::acc_t  acc_o
);

  localparam int F    = cfpi_pkg::FRACTION_BITS;
  localparam int T1_W = cfpi_pkg::T1_W;
  localparam int T2_W = cfpi_pkg::T2_W;
  localparam int LO_W = cfpi_pkg::LO_W;
  localparam int HI_W = cfpi_pkg::HI_W;
  localparam int M_W  = cfpi_pkg::M_W;
  localparam int X_W  = cfpi_pkg::X_W;
  localparam int SB   = cfpi_pkg::SAMPLE_BITS;

  logic [3:0] valid_q;

  // stage 2
  logic signed [cfpi_pkg::C0_W+M_W:0] prod0;
  logic signed [T1_W-1:0]             t1_d, t1_q;
  logic signed [cfpi_pkg::C2_W-1:0]   c2_q;
  logic signed [SB-1:0]               p1_s2_q;
  logic        [M_W-1:0]              m_s2_q;

  // stage 3
  logic signed [T1_W+M_W:0]           prod1;
  logic signed [T2_W-1:0]             t2_d, t2_q;
  logic signed [SB-1:0]               p1_s3_q;
  logic        [M_W-1:0]              m_s3_q;

  // stage 4
  logic        [LO_W+M_W-1:0]         pp_lo_d, pp_lo_q;
  logic signed [HI_W+M_W:0]           pp_hi_d, pp_hi_q;
  logic signed [SB-1:0]               p1_s4_q;

  // stage 5
  cfpi_pkg::acc_t                     acc_d, acc_q;

  assign prod0 = coef_i.c0 * $signed({1'b0, coef_i.m});
  assign t1_d  = T1_W'(prod0) + (T1_W'(coef_i.c1) <<< F);

  assign prod1 = t1_q * $signed({1'b0, m_s2_q});
  assign t2_d  = T2_W'(prod1) + (T2_W'(c2_q) <<< (2 * F));

  assign pp_lo_d = t2_q[LO_W-1:0] * m_s3_q;
  assign pp_hi_d = $signed(t2_q[T2_W-1:LO_W]) * $signed({1'b0, m_s3_q});

  // Recombine the partial products and add 2p1 * U^3.
  assign acc_d = (X_W'(pp_hi_q) <<< LO_W) + $signed(X_W'(pp_lo_q))
               + (X_W'(p1_s4_q) <<< (3 * F + 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= {valid_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    t1_q    <= t1_d;
    c2_q    <= coef_i.c2;
    p1_s2_q <= coef_i.p1;
    m_s2_q  <= coef_i.m;

    t2_q    <= t2_d;
    p1_s3_q <= p1_s2_q;
    m_s3_q  <= m_s2_q;

    pp_lo_q <= pp_lo_d;
    pp_hi_q <= pp_hi_d;
    p1_s4_q <= p1_s3_q;

    acc_q   <= acc_d;
  end

  assign valid_o = valid_q[3];
  assign acc_o   = acc_q;

endmodule

/* sv/cfpi_round.sv */
// Last stage: truncate toward zero, saturate to the sample range, drive the results.
// Depends on cfpi_pkg.
module cfpi_round (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    valid_i,
  input  cfpi_pkg::acc_t                          acc_i,
  output logic                                    valid_o,
  output logic signed [cfpi_pkg::SAMPLE_BITS-1:0] estimate_o,
  output logic                                    saturated_o
);

  localparam int X_W   = cfpi_pkg::X_W;
  localparam int SHIFT = cfpi_pkg::SHIFT;
  localparam int Q_W   = cfpi_pkg::Q_W;
  localparam int SB    = cfpi_pkg::SAMPLE_BITS;

  localparam logic signed [Q_W-1:0] POS_LIM = Q_W'((1 << (SB - 1)) - 1);
  localparam logic signed [Q_W-1:0] NEG_LIM = -Q_W'(1 << (SB - 1));

  logic                   neg;
  logic [X_W-1:0]         biased;
  logic signed [Q_W-1:0]  q;
  logic signed [SB-1:0]   estimate_d, estimate_q;
  logic                   sat_d, sat_q;
  logic                   valid_q;

  // Add 2^SHIFT - 1 to negative values so the shift truncates toward zero.
  assign neg    = acc_i[X_W-1];
  assign biased = acc_i + {{(X_W - SHIFT){1'b0}}, {SHIFT{neg}}};
  assign q      = $signed(biased[X_W-1:SHIFT]);

  always_comb begin
    if (q > POS_LIM) begin
      estimate_d = POS_LIM[SB-1:0];
      sat_d      = 1'b1;
    end else if (q < NEG_LIM) begin
      estimate_d = NEG_LIM[SB-1:0];
      sat_d      = 1'b1;
    end else begin
      estimate_d = q[SB-1:0];
      sat_d      = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    estimate_q <= estimate_d;
    sat_q      <= sat_d;
  end

  assign valid_o     = valid_q;
  assign estimate_o  = estimate_q;
  assign saturated_o = sat_q;

endmodule

/* sv/cubic_four_point_interpolator.sv */
// Top level of the Catmull-Rom four-point cubic interpolator.
// Depends on cfpi_pkg, cfpi_coef, cfpi_horner and cfpi_round.

// The block takes one transfer per clock: a window of four signed samples and
// a Q1.16 fraction (65536 is 1.0, larger values act as 1.0) is accepted on
// every rising edge with start high, since busy is always low. At the end of
// the stage chain the estimate appears for exactly one cycle with done_o
// high; results leave in the order their windows came in, one per window,
// and the receiver has no way to hold them off, so capture done_o whenever
// it rises. The stage chain is: coefficients, two Horner multiply-adds,
// the final multiply split into two partial products, recombination, and
// truncation toward zero with saturation. Throughput is one item per cycle,
// set by the fully pipelined multipliers. saturated_o marks an estimate that
// fell outside the 16-bit range and was clamped.
module cubic_four_point_interpolator (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    start,
  output logic                                    busy,
  input  logic signed [cfpi_pkg::SAMPLE_BITS-1:0] sample_before_i,
  input  logic signed [cfpi_pkg::SAMPLE_BITS-1:0] sample_start_i,
  input  logic signed [cfpi_pkg::SAMPLE_BITS-1:0] sample_end_i,
  input  logic signed [cfpi_pkg::SAMPLE_BITS-1:0] sample_after_i,
  input  logic        [cfpi_pkg::M_W-1:0]         fraction_i,
  output logic                                    done_o,
  output logic signed [cfpi_pkg::SAMPLE_BITS-1:0] estimate_o,
  output logic                                    saturated_o
);

  localparam int SB = cfpi_pkg::SAMPLE_BITS;

  logic            accept;
  logic            coef_valid;
  cfpi_pkg::coef_t coef;
  logic            acc_valid;
  cfpi_pkg::acc_t  acc;

  // Never stall: every stage advances each cycle.
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  cfpi_coef u_coef (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (accept),
    .p0_i       (sample_before_i),
    .p1_i       (sample_start_i),
    .p2_i       (sample_end_i),
    .p3_i       (sample_after_i),
    .fraction_i (fraction_i),
    .valid_o    (coef_valid),
    .coef_o     (coef)
  );

  cfpi_horner u_horner (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (coef_valid),
    .coef_i  (coef),
    .valid_o (acc_valid),
    .acc_o   (acc)
  );

  cfpi_round u_round (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (acc_valid),
    .acc_i       (acc),
    .valid_o     (done_o),
    .estimate_o  (estimate_o),
    .saturated_o (saturated_o)
  );

  // A result strobe only ever follows an accepted window by the pipeline depth.
  a_done_follows_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start, 6))
    else $error("result strobe without an accepted window six cycles earlier");

  // Every accepted window yields a result.
  a_start_gives_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##6 done_o)
    else $error("accepted window produced no result");

  // A clamped result sits exactly on a range limit.
  a_sat_at_limit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && saturated_o) |->
      (estimate_o == $signed(SB'((1 << (SB - 1)) - 1)) ||
       estimate_o == $signed(SB'(1 << (SB - 1)))))
    else $error("saturated result is not at a range limit");

  // A zero fraction returns the interval start sample unchanged.
  a_zero_fraction : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && $past(fraction_i, 6) == '0) |->
      (estimate_o == $past(sample_start_i, 6) && !saturated_o))
    else $error("zero fraction did not return the start sample");

endmodule
